// ===== sv/owd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owd_pkg
// Shared types, register indexes and reset values of the open-window detector.
// ----------------------------------------------------------------------------
package owd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_THRESHOLD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_SPIKE_THRESH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_CHANGE_THRESH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_LEVEL    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_DROP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_VELOCITY  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FREEZE_LIMIT     = 3'd6;

    // Reset values
    localparam logic [14:0] RST_DROP_THRESHOLD    = 15'd100;
    localparam logic [15:0] RST_VEL_SPIKE_THRESH  = 16'd4500;
    localparam logic [13:0] RST_HUM_CHANGE_THRESH = 14'd500;
    localparam logic [7:0]  RST_CONFIRM_LEVEL     = 8'd2;
    localparam logic [14:0] RST_SETTLE_DROP       = 15'd20;
    localparam logic [15:0] RST_SETTLE_VELOCITY   = 16'd1500;
    localparam logic [14:0] RST_FREEZE_LIMIT      = 15'd400;

    localparam logic [7:0]  CONFIRM_MAX = 8'hFF;

    typedef struct packed {
        logic [14:0] drop_threshold;
        logic [15:0] velocity_spike_threshold;
        logic [13:0] humidity_change_threshold;
        logic [7:0]  confirm_level;
        logic [14:0] settle_drop_limit;
        logic [15:0] settle_velocity_limit;
        logic [14:0] freeze_limit;       // two's complement
    } t_cfg;

    typedef struct packed {
        logic        win_open;
        logic [7:0]  confirm_count;
        logic [15:0] temp_fall;          // two's complement
        logic        frost;
    } t_result;

endpackage

// ===== sv/open_window_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_window_detector
// Open-window detection from temperature, humidity and air velocity samples.
// ----------------------------------------------------------------------------
// Each input transaction carries one sample and produces exactly one result
// transaction. A sample is registered at the input, evaluated against the
// previous sample and the confirmation counter, and the result is registered
// at the output. The output register is loaded from the input register only
// when it is empty or being drained, so a stalled output side holds a sample
// in the input register. A new sample is taken every cycle as long as the
// output side keeps draining. The update of the previous-sample and counter
// registers on each advance is what sets that rate. Configuration writes are
// accepted at any time but must only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module open_window_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [14:0]                       i_air_temp,
    input  logic [13:0]                       i_humidity,
    input  logic [15:0]                       i_air_velocity,
    // result output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_win_open,
    output logic [7:0]                        o_confirm_count,
    output logic [15:0]                       o_temp_fall,
    output logic                              o_frost,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [owd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [owd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    owd_pkg::t_cfg    w_cfg;
    owd_pkg::t_result w_result;

    // Input stage
    logic        r_in_valid;
    logic [14:0] r_in_temp;
    logic [13:0] r_in_hum;
    logic [15:0] r_in_vel;

    // Output stage
    logic             r_out_valid;
    owd_pkg::t_result r_out;

    logic w_out_free;
    logic w_advance;
    logic w_in_accept;
    logic n_in_valid;

    // The output register can take a new result when empty or being drained
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // Evaluate the held sample and commit state only when its result can move
    assign w_advance   = r_in_valid && w_out_free;
    // Stall only when the input stage is full and cannot move this cycle
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    owd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    owd_detect u_detect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_cfg          (w_cfg),
        .i_air_temp     (r_in_temp),
        .i_humidity     (r_in_hum),
        .i_air_velocity (r_in_vel),
        .o_result       (w_result)
    );

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_out_free) begin
                r_out_valid <= w_advance;
            end
        end
    end

    // Payload: capture a sample on acceptance, a result on advance
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_temp <= i_air_temp;
            r_in_hum  <= i_humidity;
            r_in_vel  <= i_air_velocity;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_win_open      = r_out.win_open;
    assign o_confirm_count = r_out.confirm_count;
    assign o_temp_fall     = r_out.temp_fall;
    assign o_frost         = r_out.frost;

endmodule

// ===== sv/owd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owd_cfg_regs
// Configuration register file, written by index over a valid/ready channel.
// ----------------------------------------------------------------------------
module owd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [owd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [owd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_cfg_ready,
    output owd_pkg::t_cfg                     o_cfg
);

    owd_pkg::t_cfg r_cfg;

    // The user must write only while the block is idle; not enforced here, so always take writes
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_threshold            <= owd_pkg::RST_DROP_THRESHOLD;
            r_cfg.velocity_spike_threshold  <= owd_pkg::RST_VEL_SPIKE_THRESH;
            r_cfg.humidity_change_threshold <= owd_pkg::RST_HUM_CHANGE_THRESH;
            r_cfg.confirm_level             <= owd_pkg::RST_CONFIRM_LEVEL;
            r_cfg.settle_drop_limit         <= owd_pkg::RST_SETTLE_DROP;
            r_cfg.settle_velocity_limit     <= owd_pkg::RST_SETTLE_VELOCITY;
            r_cfg.freeze_limit              <= owd_pkg::RST_FREEZE_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                owd_pkg::REG_DROP_THRESHOLD: begin
                    r_cfg.drop_threshold <= i_cfg_data[14:0];
                end
                owd_pkg::REG_VEL_SPIKE_THRESH: begin
                    r_cfg.velocity_spike_threshold <= i_cfg_data;
                end
                owd_pkg::REG_HUM_CHANGE_THRESH: begin
                    r_cfg.humidity_change_threshold <= i_cfg_data[13:0];
                end
                owd_pkg::REG_CONFIRM_LEVEL: begin
                    r_cfg.confirm_level <= i_cfg_data[7:0];
                end
                owd_pkg::REG_SETTLE_DROP: begin
                    r_cfg.settle_drop_limit <= i_cfg_data[14:0];
                end
                owd_pkg::REG_SETTLE_VELOCITY: begin
                    r_cfg.settle_velocity_limit <= i_cfg_data;
                end
                owd_pkg::REG_FREEZE_LIMIT: begin
                    r_cfg.freeze_limit <= i_cfg_data[14:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

endmodule

// ===== sv/owd_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owd_detect
// Previous-sample state, confirmation counter and open/closed decision.
// ----------------------------------------------------------------------------
module owd_detect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  owd_pkg::t_cfg     i_cfg,
    input  logic [14:0]       i_air_temp,
    input  logic [13:0]       i_humidity,
    input  logic [15:0]       i_air_velocity,
    output owd_pkg::t_result  o_result
);

    logic [14:0] r_last_temp;
    logic [13:0] r_last_hum;
    logic [15:0] r_last_vel;
    logic [7:0]  r_conf;
    logic        r_open;

    logic [7:0]  n_conf;
    logic        n_open;

    logic [15:0] w_drop;
    logic [14:0] w_drop_abs;
    logic [14:0] w_hum_diff;
    logic [13:0] w_hum_abs;
    logic [16:0] w_vel_diff;
    logic        w_drop_hit;
    logic        w_vel_hit;
    logic        w_hum_hit;
    logic        w_hit;
    logic        w_settle;

    // Differences, one bit wider than the operands
    assign w_drop     = {r_last_temp[14], r_last_temp} - {i_air_temp[14], i_air_temp};
    assign w_hum_diff = {1'b0, i_humidity} - {1'b0, r_last_hum};
    assign w_vel_diff = {1'b0, i_air_velocity} - {1'b0, r_last_vel};

    assign w_drop_abs = w_drop[15] ? (~w_drop[14:0] + 15'd1) : w_drop[14:0];
    assign w_hum_abs  = w_hum_diff[14] ? (~w_hum_diff[13:0] + 14'd1) : w_hum_diff[13:0];

    assign w_drop_hit = !w_drop[15] && (w_drop[14:0] > i_cfg.drop_threshold);
    assign w_vel_hit  = !w_vel_diff[16] && (w_vel_diff[15:0] > i_cfg.velocity_spike_threshold);
    assign w_hum_hit  = w_hum_abs > i_cfg.humidity_change_threshold;
    assign w_hit      = w_drop_hit && (w_vel_hit || w_hum_hit);

    assign w_settle = r_open && (w_drop_abs < i_cfg.settle_drop_limit)
                      && (i_air_velocity < i_cfg.settle_velocity_limit);

    always_comb begin
        n_conf = r_conf;
        if (w_hit) begin
            if (r_conf != owd_pkg::CONFIRM_MAX) begin
                n_conf = r_conf + 8'd1;
            end
        end else if (r_conf != 8'd0) begin
            n_conf = r_conf - 8'd1;
        end

        // Reaching the confirm level wins over the settle test
        if (n_conf >= i_cfg.confirm_level) begin
            n_open = 1'b1;
        end else if (w_settle) begin
            n_open = 1'b0;
        end else begin
            n_open = r_open;
        end
    end

    assign o_result.win_open      = n_open;
    assign o_result.confirm_count = n_conf;
    assign o_result.temp_fall     = w_drop;
    assign o_result.frost         = $signed(i_air_temp) < $signed(i_cfg.freeze_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_temp <= '0;
            r_last_hum  <= '0;
            r_last_vel  <= '0;
            r_conf      <= '0;
            r_open      <= 1'b0;
        end else if (i_advance) begin
            r_last_temp <= i_air_temp;
            r_last_hum  <= i_humidity;
            r_last_vel  <= i_air_velocity;
            r_conf      <= n_conf;
            r_open      <= n_open;
        end
    end

    a_hold_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_conf) && $stable(r_open) && $stable(r_last_temp))
        else $error("detector state changed without a transaction");

    a_count_saturates : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && w_hit && (r_conf == owd_pkg::CONFIRM_MAX)
        |=> r_conf == owd_pkg::CONFIRM_MAX)
        else $error("confirmation counter wrapped at top");

    a_count_floor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !w_hit && (r_conf == 8'd0) |=> r_conf == 8'd0)
        else $error("confirmation counter wrapped at zero");

    a_open_on_confirm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (n_conf >= i_cfg.confirm_level) |=> r_open)
        else $error("window not open after reaching confirm level");

endmodule
